/* rtl/cst_pkg.sv */
// shared types and constants for the compacting slot table
// no dependencies; imported by every module of the block
package cst_pkg;

  // table geometry
  localparam int SLOTS = 128;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  // compare width that holds both a slot_index field and a count
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_FIND   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] item;
    logic [6:0]  slot_index;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  slot;
    logic [15:0] overflow_item;
    logic [7:0]  count;
  } out_word_t;

  // broadcast control from the sequencer to the row of cells
  typedef struct packed {
    logic             clear;
    logic             add_en;
    logic             rm_en;
    logic             probe_load;
    logic             probe_shift;
    logic [15:0]      item;
    logic [7:0]       key;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rm_addr;
  } cell_ctrl_t;

endpackage

/* rtl/cst_cell.sv */
// one slot of the table: holds an entry and a search token bit
// depends on cst_pkg for the broadcast control struct
module cst_cell import cst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  logic        add_sel_i,
  input  logic        shift_sel_i,
  input  logic [15:0] upper_i,
  input  logic        probe_i,
  output logic [15:0] data_o,
  output logic        probe_o,
  output logic        hit_o
);

  logic [15:0] data_q, data_d;
  logic        probe_q, probe_d;

  // entry update: clear, add at the selected slot, or take the upper neighbor
  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.clear) begin
      data_d = '0;
    end else if (ctrl_i.add_en && add_sel_i) begin
      data_d = ctrl_i.item;
    end else if (ctrl_i.rm_en && shift_sel_i) begin
      data_d = upper_i;
    end else begin
      data_d = data_q;
    end
  end

  // search token moves one cell up per cycle, dropped when the scan stops
  assign probe_d = ctrl_i.probe_shift ? probe_i : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q  <= '0;
      probe_q <= 1'b0;
    end else begin
      data_q  <= data_d;
      probe_q <= probe_d;
    end
  end

  // low byte compare, empty slots included
  assign hit_o   = probe_q && (data_q[7:0] == ctrl_i.key);
  assign data_o  = data_q;
  assign probe_o = probe_q;

endmodule

/* rtl/cst_ctrl.sv */
// sequencer: decodes commands, keeps count and overflow latch, runs the find scan
// depends on cst_pkg; drives the cell row through cell_ctrl_t
module cst_ctrl import cst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  in_word_t         in_word_i,
  input  logic [SLOTS-1:0] hits_i,
  output logic             busy_o,
  output cell_ctrl_t       ctrl_o,
  output logic             done_o,
  output out_word_t        res_word_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      ov_q, ov_d;
  logic [7:0]       key_q, key_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             done_q, done_d;
  out_word_t        res_q, res_d;

  logic             accept;
  logic             hit_any;
  logic             scan_last;
  logic             table_full;
  logic [CMP_W-1:0] idx_ext;
  logic             idx_ok;
  logic             idx_live;

  assign accept     = start && (state_q == S_IDLE);
  assign hit_any    = |hits_i;
  // entries past the occupied prefix are all empty, so the scan ends at count
  assign scan_last  = (CNT_W'(pos_q) == count_q) || (pos_q == IDX_W'(SLOTS - 1));
  assign table_full = (count_q == CNT_W'(SLOTS));
  assign idx_ext    = CMP_W'(in_word_i.slot_index);
  assign idx_ok     = idx_ext < CMP_W'(SLOTS);
  assign idx_live   = idx_ext < CMP_W'(count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_word_i.mode == MODE_FIND)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit_any || scan_last) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    ctrl_o     = '0;
    ctrl_o.key = key_q;
    count_d    = count_q;
    ov_d       = ov_q;
    key_d      = key_q;
    pos_d      = pos_q;
    done_d     = 1'b0;
    res_d      = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_word_i.mode)
            MODE_CLEAR: begin
              ctrl_o.clear = 1'b1;
              count_d      = '0;
              done_d       = 1'b1;
              res_d.status = STATUS_OK;
              res_d.slot   = '0;
            end
            MODE_ADD: begin
              done_d = 1'b1;
              if (table_full) begin
                ov_d         = in_word_i.item;
                res_d.status = STATUS_FULL;
                res_d.slot   = '0;
              end else begin
                // table stays compact, so the first empty slot is at count
                ov_d           = '0;
                ctrl_o.add_en  = 1'b1;
                ctrl_o.item    = in_word_i.item;
                ctrl_o.wr_addr = count_q[IDX_W-1:0];
                count_d        = count_q + CNT_W'(in_word_i.item != 16'd0);
                res_d.status   = STATUS_OK;
                res_d.slot     = 7'(count_q);
              end
            end
            MODE_REMOVE: begin
              done_d     = 1'b1;
              res_d.slot = '0;
              if (idx_ok) begin
                ctrl_o.rm_en   = 1'b1;
                ctrl_o.rm_addr = idx_ext[IDX_W-1:0];
                res_d.status   = STATUS_OK;
                if (idx_live) begin
                  count_d = count_q - CNT_W'(1);
                end
              end else begin
                res_d.status = STATUS_BAD_INDEX;
              end
            end
            MODE_FIND: begin
              key_d              = in_word_i.item[7:0];
              pos_d              = '0;
              ctrl_o.probe_load  = 1'b1;
              ctrl_o.probe_shift = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          done_d       = 1'b1;
          res_d.status = STATUS_OK;
          res_d.slot   = 7'(pos_q);
        end else if (scan_last) begin
          done_d       = 1'b1;
          res_d.status = STATUS_NOT_FOUND;
          res_d.slot   = '0;
        end else begin
          ctrl_o.probe_shift = 1'b1;
          pos_d              = pos_q + IDX_W'(1);
        end
      end
    endcase
    if (done_d) begin
      res_d.overflow_item = ov_d;
      res_d.count         = 8'(count_d);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ov_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  assign busy_o     = (state_q == S_SCAN);
  assign done_o     = done_q;
  assign res_word_o = res_q;

endmodule

/* rtl/compacting_slot_table_top.sv */
// compacting slot table: sequencer plus a row of SLOTS cells (cst_cell, cst_ctrl, cst_pkg)
// clear, add, remove: result strobed on done_o the cycle after start
// find: a token walks the cell row one slot per cycle; the block is busy during the walk
// done_o marks every result for one cycle only; the receiver cannot stall the block
// async active-low reset empties every slot, clears count and overflow latch
module compacting_slot_table_top import cst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_word_t  in_word_i,
  output logic      busy,
  output logic      done_o,
  output out_word_t res_word_o
);

  cell_ctrl_t       cell_ctrl;
  logic [SLOTS-1:0] hits;
  logic [SLOTS-1:0] probes;
  logic [SLOTS-1:0] add_sel;
  logic [SLOTS-1:0] shift_sel;
  logic [15:0]      data  [SLOTS];
  logic [15:0]      upper [SLOTS];
  logic [SLOTS-1:0] probe_in;

  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .in_word_i  (in_word_i),
    .hits_i     (hits),
    .busy_o     (busy),
    .ctrl_o     (cell_ctrl),
    .done_o     (done_o),
    .res_word_o (res_word_o)
  );

  // row of cells, each linked to its neighbors for shift-down and token walk
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign add_sel[i]   = (cell_ctrl.wr_addr == IDX_W'(i));
    assign shift_sel[i] = (IDX_W'(i) >= cell_ctrl.rm_addr);
    if (i == SLOTS - 1) begin : g_top
      assign upper[i] = '0;
    end else begin : g_mid
      assign upper[i] = data[i+1];
    end
    if (i == 0) begin : g_first
      assign probe_in[i] = cell_ctrl.probe_load;
    end else begin : g_rest
      assign probe_in[i] = probes[i-1];
    end

    cst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .add_sel_i   (add_sel[i]),
      .shift_sel_i (shift_sel[i]),
      .upper_i     (upper[i]),
      .probe_i     (probe_in[i]),
      .data_o      (data[i]),
      .probe_o     (probes[i]),
      .hit_o       (hits[i])
    );
  end

  // at most one search token in the row
  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(probes))
    else $error("more than one search token in the cell row");

  // a find holds the block busy in the next cycle
  a_find_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_word_i.mode == MODE_FIND) |=> busy)
    else $error("find accepted but block not busy");

  // every other command gives its result in the next cycle
  a_cmd_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_word_i.mode != MODE_FIND) |=> done_o)
    else $error("command result missing");

  // a full report only comes with a full table
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_word_o.status == STATUS_FULL) |-> (res_word_o.count == 8'(SLOTS)))
    else $error("full reported with free slots");

endmodule

/* bench/compacting_slot_table_checker.sv */
// result checker for the compacting slot table: tracks the table contents,
// predicts each result word and compares it with what the block strobes out
// depends on cst_pkg for the word types and the mode and status codes
`timescale 1ns / 100ps

module compacting_slot_table_checker import cst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word_i,
  input  logic      done_i,
  input  out_word_t res_word_i,
  output int        fail_count_o,
  output int        pending_o
);

  // shadow of the table and the overflow latch
  logic [15:0] shadow_slots [SLOTS];
  logic [15:0] shadow_overflow;
  out_word_t   expected_words [$];
  out_word_t   predicted;
  out_word_t   oldest;
  int          mismatches;

  function automatic logic [7:0] occupied_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_slots[i] != 16'd0) n++;
    end
    return 8'(n);
  endfunction

  // apply one command word to the shadow table and build its result word
  task automatic apply_command(input in_word_t cmd, output out_word_t res);
    status_e st;
    int      hit;
    int      dst;
    bit      done_scan;
    st = STATUS_OK;
    hit = 0;
    done_scan = 1'b0;
    case (cmd.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) shadow_slots[i] = 16'd0;
      end
      MODE_ADD: begin
        shadow_overflow = 16'd0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done_scan && shadow_slots[i] == 16'd0) begin
            shadow_slots[i] = cmd.item;
            hit = i;
            done_scan = 1'b1;
          end
        end
        if (!done_scan) begin
          shadow_overflow = cmd.item;
          st = STATUS_FULL;
        end
      end
      MODE_REMOVE: begin
        if (int'(cmd.slot_index) >= SLOTS) begin
          st = STATUS_BAD_INDEX;
        end else begin
          shadow_slots[cmd.slot_index] = 16'd0;
          // squeeze occupied entries down, keeping their order
          dst = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (shadow_slots[i] != 16'd0) begin
              shadow_slots[dst] = shadow_slots[i];
              dst++;
            end
          end
          for (int i = dst; i < SLOTS; i++) shadow_slots[i] = 16'd0;
        end
      end
      default: begin
        // empty slots take part in the low byte compare
        for (int i = 0; i < SLOTS; i++) begin
          if (!done_scan && shadow_slots[i][7:0] == cmd.item[7:0]) begin
            hit = i;
            done_scan = 1'b1;
          end
        end
        if (!done_scan) st = STATUS_NOT_FOUND;
      end
    endcase
    res.status        = st;
    res.slot          = 7'(hit);
    res.overflow_item = shadow_overflow;
    res.count         = occupied_slots();
  endtask

  // check strobed words against the oldest prediction, then log new commands
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) shadow_slots[i] = 16'd0;
      shadow_overflow = 16'd0;
      expected_words.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: status %0d slot %0d overflow %h count %0d",
                   $time, res_word_i.status, res_word_i.slot,
                   res_word_i.overflow_item, res_word_i.count);
        end else begin
          oldest = expected_words.pop_front();
          if (res_word_i !== oldest) begin
            mismatches++;
            $display("%0t: mismatch: expected status %0d slot %0d overflow %h count %0d",
                     $time, oldest.status, oldest.slot, oldest.overflow_item,
                     oldest.count);
            $display("%0t:           actual   status %0d slot %0d overflow %h count %0d",
                     $time, res_word_i.status, res_word_i.slot,
                     res_word_i.overflow_item, res_word_i.count);
          end
        end
      end
      if (start && !busy) begin
        apply_command(in_word_i, predicted);
        expected_words.push_back(predicted);
      end
      fail_count_o <= mismatches;
      pending_o <= expected_words.size();
    end
  end

endmodule

/* bench/compacting_slot_table_top_test.sv */
// top of the compacting slot table bench: clock, reset, command stimulus
// and the verdict; depends on cst_pkg, the block and the result checker
`timescale 1ns / 100ps

module compacting_slot_table_top_test import cst_pkg::*; ();

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_WORDS = 1550;
  localparam int CALM_TAIL    = 200;
  localparam int SETTLE_CYCLES = SLOTS + 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word_i = '0;
  logic      busy;
  logic      done_o;
  out_word_t res_word_o;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  int        words_sent = 0;

  compacting_slot_table_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .in_word_i  (in_word_i),
    .busy       (busy),
    .done_o     (done_o),
    .res_word_o (res_word_o)
  );

  compacting_slot_table_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_word_i    (in_word_i),
    .done_i       (done_o),
    .res_word_i   (res_word_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // hold a command word until the block takes it
  task automatic send_word(input mode_e m, input logic [15:0] item, input logic [6:0] idx);
    in_word_t w;
    w.mode = m;
    w.item = item;
    w.slot_index = idx;
    start <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  // drop start for a while, with junk on the command bus
  task automatic idle_for(input int n);
    start <= 1'b0;
    in_word_i <= in_word_t'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // item values lean toward a few low bytes so that finds hit often
  function automatic logic [15:0] pick_item();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return {8'($urandom), 8'($urandom_range(0, 15))};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_index();
    if ($urandom_range(0, 1) == 0) return 7'($urandom_range(0, 31));
    return 7'($urandom);
  endfunction

  task automatic maybe_idle(input int gap_odds);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) idle_for($urandom_range(1, 14));
  endtask

  // clear, fill to the brim, overflow, find, remove and refill, then show the latch survives a clear
  task automatic fill_table(input int gap_odds);
    logic [15:0] v;
    send_word(MODE_CLEAR, pick_item(), pick_index());
    repeat (SLOTS + $urandom_range(1, 4)) begin
      v = pick_item();
      if (v == 16'h0000) v = 16'h0100;
      send_word(MODE_ADD, v, pick_index());
      maybe_idle(gap_odds);
    end
    repeat ($urandom_range(2, 6)) send_word(MODE_FIND, pick_item(), pick_index());
    send_word(MODE_REMOVE, pick_item(), 7'($urandom_range(0, SLOTS - 1)));
    send_word(MODE_ADD, 16'hBEEF, pick_index());
    send_word(MODE_ADD, 16'hCAFE, pick_index());
    send_word(MODE_CLEAR, pick_item(), pick_index());
    send_word(MODE_FIND, 16'h5500, pick_index());
  endtask

  task automatic random_word(input int add_pct, input int gap_odds);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      send_word(mode_e'($urandom_range(0, 3)), 16'($urandom), 7'($urandom));
    else if (r < 10)
      send_word(MODE_CLEAR, pick_item(), pick_index());
    else if (r < 10 + add_pct)
      send_word(MODE_ADD, pick_item(), pick_index());
    else if (r < 10 + add_pct + (90 - add_pct) / 2)
      send_word(MODE_REMOVE, pick_item(), pick_index());
    else
      send_word(MODE_FIND, pick_item(), pick_index());
    maybe_idle(gap_odds);
  endtask

  initial begin
    int gap_odds;
    int target;
    int odds_pick [3];

    odds_pick = '{0, 8, 3};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-table finds, adds of extreme values, finds, removes, clear, then a find and a remove
    send_word(MODE_FIND, 16'h1200, 7'd0);
    send_word(MODE_FIND, 16'h00AB, 7'd127);
    send_word(MODE_ADD, 16'h0000, 7'd0);
    send_word(MODE_ADD, 16'hFFFF, 7'd0);
    send_word(MODE_ADD, 16'h0001, 7'd0);
    send_word(MODE_ADD, 16'h8000, 7'd0);
    send_word(MODE_ADD, 16'h7F01, 7'd0);
    send_word(MODE_FIND, 16'h00FF, 7'd0);
    send_word(MODE_FIND, 16'hAB00, 7'd0);
    send_word(MODE_FIND, 16'h3301, 7'd0);
    send_word(MODE_FIND, 16'hFF80, 7'd0);
    send_word(MODE_REMOVE, 16'hFFFF, 7'd0);
    send_word(MODE_REMOVE, 16'h0000, 7'd127);
    send_word(MODE_REMOVE, 16'h0000, 7'd1);
    send_word(MODE_FIND, 16'h0001, 7'd0);
    send_word(MODE_FIND, 16'h0000, 7'd0);
    send_word(MODE_CLEAR, 16'hFFFF, 7'd127);
    send_word(MODE_FIND, 16'h0000, 7'd0);
    send_word(MODE_REMOVE, 16'h0000, 7'd64);
    wait_drained();

    // random: episodes of varying add pressure, with full-table runs
    target = words_sent + RANDOM_WORDS;
    fill_table(3);
    while (words_sent < target) begin
      gap_odds = (words_sent >= target - CALM_TAIL) ? 0 : odds_pick[$urandom_range(0, 2)];
      case ($urandom_range(0, 7))
        0: fill_table(gap_odds);
        1: begin
          wait_drained();
          repeat ($urandom_range(20, 80)) random_word(45, gap_odds);
        end
        default: begin
          repeat ($urandom_range(40, 160)) random_word($urandom_range(30, 70), gap_odds);
        end
      endcase
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cst_pkg.sv
rtl/cst_cell.sv
rtl/cst_ctrl.sv
rtl/compacting_slot_table_top.sv
bench/compacting_slot_table_checker.sv
bench/compacting_slot_table_top_test.sv
